### sv/dtv_pkg.sv
// ---------------------------------------------------------------------------
// dtv_pkg
// Types, constants and record-type helpers for the discovery reply validator.
// ---------------------------------------------------------------------------
package dtv_pkg;

    localparam int MAX_PACKET_BYTES_DEF = 4096;
    localparam int MAX_TEXT_CHARS_DEF   = 255;

    localparam int SEEN_W = 10;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_TYPE    = 3'd1,
        PH_SIZE_HI = 3'd2,
        PH_SIZE_LO = 3'd3,
        PH_VALUE   = 3'd4
    } phase_t;

    typedef struct packed {
        logic valid;
        logic is_match;
    } res_t;

    localparam logic [7:0] HDR_VERSION = 8'd1;
    localparam logic [7:0] HDR_ZERO    = 8'd0;

    localparam logic [7:0] TYPE_MAC     = 8'd1;
    localparam logic [7:0] TYPE_MAC_EXT = 8'd2;
    localparam logic [7:0] TYPE_ADDR_A  = 8'd10;
    localparam logic [7:0] TYPE_ADDR_B  = 8'd15;
    localparam logic [7:0] TYPE_TXT_3   = 8'd3;
    localparam logic [7:0] TYPE_TXT_11  = 8'd11;
    localparam logic [7:0] TYPE_TXT_12  = 8'd12;
    localparam logic [7:0] TYPE_TXT_13  = 8'd13;
    localparam logic [7:0] TYPE_TXT_20  = 8'd20;
    localparam logic [7:0] TYPE_TXT_21  = 8'd21;
    localparam logic [7:0] TYPE_TXT_22  = 8'd22;

    localparam logic [15:0] MAC_SIZE     = 16'd6;
    localparam logic [15:0] MAC_EXT_SIZE = 16'd10;
    localparam logic [15:0] ADDR_SIZE    = 16'd4;
    localparam logic [15:0] MAC_BYTES    = 16'd6;
    localparam logic [15:0] MAC_LAST_IDX = 16'd5;

    localparam logic [7:0] PRINT_LO = 8'd32;
    localparam logic [7:0] PRINT_HI = 8'd126;

    localparam logic [3:0] ONCE_NONE = 4'd15;

    function automatic logic [3:0] once_bit(input logic [7:0] t);
        logic [3:0] r;
        unique case (t)
            TYPE_MAC:    r = 4'd0;
            TYPE_ADDR_A: r = 4'd1;
            TYPE_ADDR_B: r = 4'd2;
            TYPE_TXT_3:  r = 4'd3;
            TYPE_TXT_11: r = 4'd4;
            TYPE_TXT_12: r = 4'd5;
            TYPE_TXT_13: r = 4'd6;
            TYPE_TXT_20: r = 4'd7;
            TYPE_TXT_21: r = 4'd8;
            TYPE_TXT_22: r = 4'd9;
            default:     r = ONCE_NONE;
        endcase
        return r;
    endfunction

    function automatic logic is_text(input logic [7:0] t);
        return (t == TYPE_TXT_3) || (t == TYPE_TXT_11) || (t == TYPE_TXT_12) ||
               (t == TYPE_TXT_13) || (t == TYPE_TXT_20) || (t == TYPE_TXT_21) ||
               (t == TYPE_TXT_22);
    endfunction

    function automatic logic is_identity(input logic [7:0] t);
        return (t == TYPE_TXT_3) || (t == TYPE_TXT_12) || (t == TYPE_TXT_20) ||
               (t == TYPE_TXT_21);
    endfunction

    function automatic logic printable(input logic [7:0] b);
        return (b >= PRINT_LO) && (b <= PRINT_HI);
    endfunction

endpackage

### sv/discovery_reply_tlv_validator.sv
// ---------------------------------------------------------------------------
// discovery_reply_tlv_validator
// Streams a discovery reply byte by byte and reports whether it is a
// well-formed reply carrying a MAC and an identity text.
// ---------------------------------------------------------------------------
//  channel | ports                           | dir
//  --------+---------------------------------+-----
//  input   | s_valid s_ready s_data_byte      | in
//          | s_last_byte                      |
//  result  | m_valid m_ready m_is_match       | out
//
//  One byte per cycle while s_ready is high; the parser state updates in the accepting cycle.
//  The verdict for a packet is pushed into the result buffer when its last byte is accepted.
//  Reset is synchronous, active low, and empties the result buffer.
//  Two verdicts may be buffered; s_ready drops only when both wait.
// ---------------------------------------------------------------------------
module discovery_reply_tlv_validator #(
    parameter int MAX_PACKET_BYTES = dtv_pkg::MAX_PACKET_BYTES_DEF,
    parameter int MAX_TEXT_CHARS   = dtv_pkg::MAX_TEXT_CHARS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_is_match
);

    dtv_pkg::res_t res;
    logic          in_fire;

    assign in_fire = s_valid && s_ready;

    dtv_parser #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
        .MAX_TEXT_CHARS   (MAX_TEXT_CHARS)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .data_byte (s_data_byte),
        .last_byte (s_last_byte),
        .res       (res)
    );

    dtv_res_buf u_res_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (res),
        .can_push   (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_is_match (m_is_match)
    );

    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_last_byte) |=> m_valid)
        else $error("no result after last byte");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with empty result buffer");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

endmodule

### sv/dtv_parser.sv
// ---------------------------------------------------------------------------
// dtv_parser
// Per-byte header and record checker; gives a verdict on the last byte.
// ---------------------------------------------------------------------------
module dtv_parser #(
    parameter int MAX_PACKET_BYTES = dtv_pkg::MAX_PACKET_BYTES_DEF,
    parameter int MAX_TEXT_CHARS   = dtv_pkg::MAX_TEXT_CHARS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_fire,
    input  logic [7:0]    data_byte,
    input  logic          last_byte,
    output dtv_pkg::res_t res
);

    localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 2);
    localparam int CMP_W = (CNT_W > 17) ? CNT_W : 17;

    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [15:0]                decl_reg, decl_next;
    dtv_pkg::phase_t            phase_reg, phase_next;
    logic [7:0]                 type_reg, type_next;
    logic [15:0]                size_reg, size_next;
    logic [15:0]                idx_reg, idx_next;
    logic [7:0]                 bits_reg, bits_next;
    logic [dtv_pkg::SEEN_W-1:0] seen_reg, seen_next;
    logic                       rej_reg, rej_next;
    logic                       long_reg, long_next;
    logic                       addr_reg, addr_next;
    logic                       ident_reg, ident_next;

    logic [3:0]  ob;
    logic [15:0] full_size;
    logic [15:0] chars;
    logic [7:0]  or_bits;

    always_comb begin
        cnt_next   = cnt_reg;
        decl_next  = decl_reg;
        phase_next = phase_reg;
        type_next  = type_reg;
        size_next  = size_reg;
        idx_next   = idx_reg;
        bits_next  = bits_reg;
        seen_next  = seen_reg;
        rej_next   = rej_reg;
        long_next  = long_reg;
        addr_next  = addr_reg;
        ident_next = ident_reg;
        ob         = dtv_pkg::once_bit(data_byte);
        full_size  = {size_reg[15:8], data_byte};
        chars      = size_reg;
        or_bits    = bits_reg | data_byte;

        if (cnt_reg <= CNT_W'(MAX_PACKET_BYTES)) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        if (cnt_next > CNT_W'(MAX_PACKET_BYTES)) begin
            long_next = 1'b1;
        end

        if (!rej_reg && !long_next) begin
            unique case (phase_reg)
                dtv_pkg::PH_HEADER: begin
                    if (cnt_next == CNT_W'(1) && data_byte != dtv_pkg::HDR_VERSION)
                        rej_next = 1'b1;
                    else if (cnt_next == CNT_W'(2) && data_byte != dtv_pkg::HDR_ZERO)
                        rej_next = 1'b1;
                    else if (cnt_next == CNT_W'(3))
                        decl_next = {data_byte, 8'd0};
                    else if (cnt_next == CNT_W'(4)) begin
                        decl_next  = {decl_reg[15:8], data_byte};
                        phase_next = dtv_pkg::PH_TYPE;
                    end
                end
                dtv_pkg::PH_TYPE: begin
                    type_next = data_byte;
                    if (ob != dtv_pkg::ONCE_NONE) begin
                        if (seen_reg[ob]) rej_next = 1'b1;
                        seen_next[ob] = 1'b1;
                    end
                    phase_next = dtv_pkg::PH_SIZE_HI;
                end
                dtv_pkg::PH_SIZE_HI: begin
                    size_next  = {data_byte, 8'd0};
                    phase_next = dtv_pkg::PH_SIZE_LO;
                end
                dtv_pkg::PH_SIZE_LO: begin
                    size_next = full_size;
                    if (type_reg == dtv_pkg::TYPE_MAC) begin
                        if (full_size != dtv_pkg::MAC_SIZE) rej_next = 1'b1;
                    end else if (type_reg == dtv_pkg::TYPE_MAC_EXT) begin
                        if (full_size != dtv_pkg::MAC_EXT_SIZE) rej_next = 1'b1;
                    end else if (type_reg == dtv_pkg::TYPE_ADDR_A ||
                                 type_reg == dtv_pkg::TYPE_ADDR_B) begin
                        if (full_size != dtv_pkg::ADDR_SIZE) rej_next = 1'b1;
                    end
                    idx_next   = '0;
                    bits_next  = '0;
                    phase_next = (full_size == 16'd0) ? dtv_pkg::PH_TYPE : dtv_pkg::PH_VALUE;
                end
                dtv_pkg::PH_VALUE: begin
                    if (type_reg == dtv_pkg::TYPE_MAC || type_reg == dtv_pkg::TYPE_MAC_EXT) begin
                        if (idx_reg < dtv_pkg::MAC_BYTES) begin
                            if (idx_reg == 16'd0 && data_byte[0]) rej_next = 1'b1;
                            bits_next = or_bits;
                            if (idx_reg == dtv_pkg::MAC_LAST_IDX) begin
                                if (or_bits == 8'd0) rej_next = 1'b1;
                                else addr_next = 1'b1;
                            end
                        end
                    end else if (dtv_pkg::is_text(type_reg)) begin
                        if ({1'b0, idx_reg} + 17'd1 < {1'b0, size_reg}) begin
                            if (!dtv_pkg::printable(data_byte)) rej_next = 1'b1;
                        end else begin
                            if (data_byte == 8'd0) chars = size_reg - 16'd1;
                            else if (!dtv_pkg::printable(data_byte)) rej_next = 1'b1;
                            if ({1'b0, chars} > 17'(MAX_TEXT_CHARS)) rej_next = 1'b1;
                        end
                        if (idx_reg == 16'd0 && data_byte != 8'd0 &&
                            dtv_pkg::is_identity(type_reg)) begin
                            ident_next = 1'b1;
                        end
                    end
                    idx_next = idx_reg + 16'd1;
                    if (idx_next >= size_reg) phase_next = dtv_pkg::PH_TYPE;
                end
                default: rej_next = 1'b1;
            endcase
        end

        res.valid    = in_fire && last_byte;
        res.is_match = !rej_next && !long_next && phase_next == dtv_pkg::PH_TYPE &&
                       CMP_W'(cnt_next) == CMP_W'(decl_next) + CMP_W'(4) &&
                       addr_next && ident_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (in_fire && last_byte)) begin
            cnt_reg   <= '0;
            decl_reg  <= '0;
            phase_reg <= dtv_pkg::PH_HEADER;
            type_reg  <= '0;
            size_reg  <= '0;
            idx_reg   <= '0;
            bits_reg  <= '0;
            seen_reg  <= '0;
            rej_reg   <= 1'b0;
            long_reg  <= 1'b0;
            addr_reg  <= 1'b0;
            ident_reg <= 1'b0;
        end else if (in_fire) begin
            cnt_reg   <= cnt_next;
            decl_reg  <= decl_next;
            phase_reg <= phase_next;
            type_reg  <= type_next;
            size_reg  <= size_next;
            idx_reg   <= idx_next;
            bits_reg  <= bits_next;
            seen_reg  <= seen_next;
            rej_reg   <= rej_next;
            long_reg  <= long_next;
            addr_reg  <= addr_next;
            ident_reg <= ident_next;
        end
    end

endmodule

### sv/dtv_res_buf.sv
// ---------------------------------------------------------------------------
// dtv_res_buf
// Two-entry result buffer; input keeps flowing while one verdict waits.
// ---------------------------------------------------------------------------
module dtv_res_buf (
    input  logic          aclk,
    input  logic          aresetn,
    input  dtv_pkg::res_t push,
    output logic          can_push,
    output logic          m_valid,
    input  logic          m_ready,
    output logic          m_is_match
);

    logic       data_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign can_push   = (cnt_reg != 2'd2);
    assign m_valid    = (cnt_reg != 2'd0);
    assign m_is_match = data_reg[rd_reg];
    assign pop        = m_valid && m_ready;

    always_comb begin
        wr_next  = push.valid ? ~wr_reg : wr_reg;
        rd_next  = pop ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, push.valid} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            data_reg[wr_reg] <= push.is_match;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule
